// ===== rtl/prq_pkg.sv =====
// Shared types and constants for the priority ready and delay queue scheduler.
`default_nettype none
package prq_pkg;

	localparam int TASK_W = 8;
	localparam int PRIO_W = 8;
	localparam int TICK_W = 16;
	localparam int CNT_W  = 5;

	typedef enum logic [1:0] {
		OP_QUEUE    = 2'd0,
		OP_DISPATCH = 2'd1,
		OP_RERUN    = 2'd2,
		OP_IDLE     = 2'd3
	} op_e_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_EMPTY  = 2'd1,
		ST_FULL   = 2'd2,
		ST_NOTASK = 2'd3
	} status_e_t;

	// Request payload.
	typedef struct packed {
		op_e_t              op;
		logic [TASK_W-1:0]  task_id;
		logic [PRIO_W-1:0]  priority_req;
		logic [TICK_W-1:0]  delay_ticks;
	} req_t;

	// Response payload.
	typedef struct packed {
		status_e_t          status;
		logic               dispatched_valid;
		logic [TASK_W-1:0]  dispatched_task;
		logic [PRIO_W-1:0]  dispatched_priority;
		logic [CNT_W-1:0]   ready_count;
		logic [CNT_W-1:0]   delayed_count;
		logic [TASK_W-1:0]  delayed_head_task;
		logic [TICK_W-1:0]  delayed_head_ticks;
	} rsp_t;

	// Queue entries as stored in memory.
	typedef struct packed {
		logic [TASK_W-1:0] task_id;
		logic [PRIO_W-1:0] key;
	} rdy_entry_t;

	typedef struct packed {
		logic [TASK_W-1:0] task_id;
		logic [TICK_W-1:0] key;
	} dly_entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic      latch;
		logic      ins_start;
		logic      ins_step;
		logic      ins_new0;
		logic      dsp_start;
		logic      dsp_step;
		logic      finish;
		logic      sel_delay;
		logic      use_running;
		status_e_t status;
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		op_e_t op;
		logic  ready_empty;
		logic  ready_full;
		logic  dly_empty;
		logic  dly_full;
		logic  delay_zero;
		logic  running_valid;
		logic  key_le;
		logic  idx_zero;
		logic  idx_last;
		logic  out_free;
	} stat_t;

endpackage
`default_nettype wire

// ===== rtl/prq_store.sv =====
// One queue memory with a single write port and a registered read port.
`default_nettype none
module prq_store #(
	parameter int DEPTH  = 16,
	parameter int DATA_W = 16
) (
	input  wire logic                     clk,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [DATA_W-1:0]        rd_data,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [DATA_W-1:0]        wr_data
);

	logic [DATA_W-1:0] mem [DEPTH];
	logic [DATA_W-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule
`default_nettype wire

// ===== rtl/prq_ctrl.sv =====
// Controller state machine that sequences queue inserts and dispatches.
`default_nettype none
module prq_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	output prq_pkg::cmd_t      cmd,
	input  wire prq_pkg::stat_t stat
);
	import prq_pkg::*;

	typedef enum logic [5:0] {
		S_IDLE     = 6'b000001,
		S_DECODE   = 6'b000010,
		S_INS_CMP  = 6'b000100,
		S_INS_NEW0 = 6'b001000,
		S_DSP_SH   = 6'b010000,
		S_DONE     = 6'b100000
	} state_t;

	state_t    state_q, state_d;
	logic      sel_q, sel_d;
	logic      use_run_q, use_run_d;
	status_e_t status_q, status_d;
	logic      tgt_full, tgt_empty;

	assign req_stall = (state_q != S_IDLE);

	// Fullness and emptiness of the queue that a rerun targets.
	always_comb begin
		tgt_full  = stat.delay_zero ? stat.ready_full : stat.dly_full;
		tgt_empty = stat.delay_zero ? stat.ready_empty : stat.dly_empty;
	end

	// Next state and command decode.
	always_comb begin
		state_d   = state_q;
		sel_d     = sel_q;
		use_run_d = use_run_q;
		status_d  = status_q;
		cmd       = '0;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.latch = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				status_d  = ST_OK;
				sel_d     = 1'b0;
				use_run_d = 1'b0;
				unique case (stat.op)
					OP_QUEUE: begin
						if (stat.ready_full) begin
							status_d = ST_FULL;
							state_d  = S_DONE;
						end else if (stat.ready_empty) begin
							state_d = S_INS_NEW0;
						end else begin
							cmd.ins_start = 1'b1;
							state_d       = S_INS_CMP;
						end
					end
					OP_DISPATCH: begin
						if (stat.ready_empty) begin
							status_d = ST_EMPTY;
							state_d  = S_DONE;
						end else begin
							cmd.dsp_start = 1'b1;
							state_d       = S_DSP_SH;
						end
					end
					OP_RERUN: begin
						if (!stat.running_valid) begin
							status_d = ST_NOTASK;
							state_d  = S_DONE;
						end else begin
							sel_d     = !stat.delay_zero;
							use_run_d = 1'b1;
							if (tgt_full) begin
								status_d = ST_FULL;
								state_d  = S_DONE;
							end else if (tgt_empty) begin
								state_d = S_INS_NEW0;
							end else begin
								cmd.ins_start = 1'b1;
								state_d       = S_INS_CMP;
							end
						end
					end
					OP_IDLE: begin
						state_d = S_DONE;
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_INS_CMP: begin
				cmd.ins_step = 1'b1;
				if (stat.key_le) begin
					state_d = S_DONE;
				end else if (stat.idx_zero) begin
					state_d = S_INS_NEW0;
				end
			end
			S_INS_NEW0: begin
				cmd.ins_new0 = 1'b1;
				state_d      = S_DONE;
			end
			S_DSP_SH: begin
				cmd.dsp_step = 1'b1;
				if (stat.idx_last) begin
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// The queue select takes effect in the decode cycle itself.
		cmd.sel_delay   = (state_q == S_DECODE) ? sel_d : sel_q;
		cmd.use_running = use_run_q;
		cmd.status      = status_q;
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			sel_q     <= 1'b0;
			use_run_q <= 1'b0;
			status_q  <= ST_OK;
		end else begin
			state_q   <= state_d;
			sel_q     <= sel_d;
			use_run_q <= use_run_d;
			status_q  <= status_d;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/prq_datapath.sv =====
// Datapath: queue memories, fill counts, scan index, current task and result register.
`default_nettype none
module prq_datapath #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire prq_pkg::req_t  req,
	output prq_pkg::rsp_t       rsp,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	input  wire prq_pkg::cmd_t  cmd,
	output prq_pkg::stat_t      stat
);
	import prq_pkg::*;

	localparam int IW = $clog2(QUEUE_DEPTH);
	localparam int FW = $clog2(QUEUE_DEPTH + 1);

	req_t              item_q;
	logic [IW-1:0]     idx_q;
	logic [FW-1:0]     rdy_fill_q, dly_fill_q;
	logic [TASK_W-1:0] run_task_q;
	logic [PRIO_W-1:0] run_prio_q;
	logic              run_valid_q;
	dly_entry_t        head_q;
	rsp_t              out_q;
	logic              out_valid_q;

	rdy_entry_t        rdy_rd, rdy_new, rdy_wr_data;
	dly_entry_t        dly_rd, dly_new, dly_wr_data;
	logic [TASK_W-1:0] ins_task;
	logic [PRIO_W-1:0] new_prio;
	logic [TICK_W-1:0] new_key, rd_key;
	logic [FW-1:0]     fill_sel;
	logic [IW-1:0]     idx_start, idx_inc, idx_dec;
	logic              key_le, idx_zero, idx_last;
	logic              rd_en, wr_en, wr_new;
	logic [IW-1:0]     rd_addr, wr_addr;
	logic              new_written;
	logic [FW+CNT_W-1:0] rdy_cnt_ext, dly_cnt_ext;
	logic              disp_ok;

	// The entry being inserted and the key it is compared against.
	always_comb begin
		ins_task = cmd.use_running ? run_task_q : item_q.task_id;
		new_prio = cmd.use_running ? run_prio_q : item_q.priority_req;
		rdy_new  = '{task_id: ins_task, key: new_prio};
		dly_new  = '{task_id: ins_task, key: item_q.delay_ticks};
		new_key  = cmd.sel_delay ? item_q.delay_ticks : TICK_W'(new_prio);
		rd_key   = cmd.sel_delay ? dly_rd.key : TICK_W'(rdy_rd.key);
		key_le   = (rd_key <= new_key);
	end

	// Scan index arithmetic.
	always_comb begin
		fill_sel  = cmd.sel_delay ? dly_fill_q : rdy_fill_q;
		idx_start = IW'(fill_sel - FW'(1));
		idx_inc   = idx_q + IW'(1);
		idx_dec   = idx_q - IW'(1);
		idx_zero  = (idx_q == '0);
		idx_last  = ((FW'(idx_q) + FW'(1)) == rdy_fill_q);
	end

	// Memory port control for insert and dispatch scans.
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_new  = 1'b0;
		if (cmd.ins_start) begin
			rd_en   = 1'b1;
			rd_addr = idx_start;
		end
		if (cmd.dsp_start) begin
			rd_en   = 1'b1;
			rd_addr = '0;
		end
		if (cmd.ins_step) begin
			// Larger keys move up one place; the new entry lands above the first smaller or equal.
			wr_en   = 1'b1;
			wr_addr = idx_inc;
			wr_new  = key_le;
			if (!key_le && !idx_zero) begin
				rd_en   = 1'b1;
				rd_addr = idx_dec;
			end
		end
		if (cmd.ins_new0) begin
			wr_en   = 1'b1;
			wr_addr = '0;
			wr_new  = 1'b1;
		end
		if (cmd.dsp_step) begin
			// Entries behind the head move down one place.
			if (!idx_zero) begin
				wr_en   = 1'b1;
				wr_addr = idx_dec;
			end
			if (!idx_last) begin
				rd_en   = 1'b1;
				rd_addr = idx_inc;
			end
		end
		rdy_wr_data = wr_new ? rdy_new : rdy_rd;
		dly_wr_data = wr_new ? dly_new : dly_rd;
		new_written = wr_en && wr_new;
	end

	prq_store #(
		.DEPTH  (QUEUE_DEPTH),
		.DATA_W ($bits(rdy_entry_t))
	) u_rdy_store (
		.clk     (clk),
		.rd_en   (rd_en && !cmd.sel_delay),
		.rd_addr (rd_addr),
		.rd_data (rdy_rd),
		.wr_en   (wr_en && !cmd.sel_delay),
		.wr_addr (wr_addr),
		.wr_data (rdy_wr_data)
	);

	prq_store #(
		.DEPTH  (QUEUE_DEPTH),
		.DATA_W ($bits(dly_entry_t))
	) u_dly_store (
		.clk     (clk),
		.rd_en   (rd_en && cmd.sel_delay),
		.rd_addr (rd_addr),
		.rd_data (dly_rd),
		.wr_en   (wr_en && cmd.sel_delay),
		.wr_addr (wr_addr),
		.wr_data (dly_wr_data)
	);

	// Request capture and scan index.
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= req;
		end
		if (cmd.ins_start) begin
			idx_q <= idx_start;
		end else if (cmd.dsp_start) begin
			idx_q <= '0;
		end else if (cmd.ins_step && !key_le && !idx_zero) begin
			idx_q <= idx_dec;
		end else if (cmd.dsp_step && !idx_last) begin
			idx_q <= idx_inc;
		end
	end

	// Fill counts and current task.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rdy_fill_q  <= '0;
			dly_fill_q  <= '0;
			run_task_q  <= '0;
			run_prio_q  <= '0;
			run_valid_q <= 1'b0;
		end else begin
			if (new_written && cmd.sel_delay) begin
				dly_fill_q <= dly_fill_q + FW'(1);
			end
			if (new_written && !cmd.sel_delay) begin
				rdy_fill_q <= rdy_fill_q + FW'(1);
			end else if (cmd.dsp_step && idx_last) begin
				rdy_fill_q <= rdy_fill_q - FW'(1);
			end
			if (cmd.dsp_step && idx_zero) begin
				run_task_q  <= rdy_rd.task_id;
				run_prio_q  <= rdy_rd.key;
				run_valid_q <= 1'b1;
			end
		end
	end

	// The delay queue only grows, so its head changes only on an insert at place zero.
	always_ff @(posedge clk) begin
		if (cmd.ins_new0 && cmd.sel_delay) begin
			head_q <= dly_new;
		end
	end

	// Result register.
	always_comb begin
		rdy_cnt_ext = {{CNT_W{1'b0}}, rdy_fill_q};
		dly_cnt_ext = {{CNT_W{1'b0}}, dly_fill_q};
		disp_ok     = (item_q.op == OP_DISPATCH) && (cmd.status == ST_OK);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.status              <= cmd.status;
			out_q.dispatched_valid    <= disp_ok;
			out_q.dispatched_task     <= disp_ok ? run_task_q : '0;
			out_q.dispatched_priority <= disp_ok ? run_prio_q : '0;
			out_q.ready_count   <= rdy_cnt_ext[CNT_W-1:0];
			out_q.delayed_count <= dly_cnt_ext[CNT_W-1:0];
			if (dly_fill_q != '0) begin
				out_q.delayed_head_task  <= head_q.task_id;
				out_q.delayed_head_ticks <= head_q.key;
			end else begin
				out_q.delayed_head_task  <= '0;
				out_q.delayed_head_ticks <= '0;
			end
		end
	end

	assign rsp       = out_q;
	assign rsp_valid = out_valid_q;

	// Status toward the controller.
	always_comb begin
		stat.op            = item_q.op;
		stat.ready_empty   = (rdy_fill_q == '0);
		stat.ready_full    = (rdy_fill_q == FW'(QUEUE_DEPTH));
		stat.dly_empty     = (dly_fill_q == '0);
		stat.dly_full      = (dly_fill_q == FW'(QUEUE_DEPTH));
		stat.delay_zero    = (item_q.delay_ticks == '0);
		stat.running_valid = run_valid_q;
		stat.key_le        = key_le;
		stat.idx_zero      = idx_zero;
		stat.idx_last      = idx_last;
		stat.out_free      = !out_valid_q || !rsp_stall;
	end

endmodule
`default_nettype wire

// ===== rtl/priority_ready_and_delay_queues_top.sv =====
// Top level of the task scheduler with a sorted ready queue and a sorted delay queue.
//
//  Channel | Valid     | Stall     | Payload
//  --------+-----------+-----------+---------------------------
//  request | req_valid | req_stall | req (op, task, priority, delay)
//  result  | rsp_valid | rsp_stall | rsp (status, dispatch, queue state)
//
// Inserts and dispatches move one entry per cycle through the queue memory's single read and
// write port while they scan the queue. Refused requests and the unused op need no scan.
// Reset clears the fill counts and the current task; queue memories need no clearing.
// A finished result waits in the result register; the next request is already taken while
// it waits, and its own result is held back until that register is free.
`default_nettype none
module priority_ready_and_delay_queues_top #(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire prq_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output prq_pkg::rsp_t      rsp
);
	import prq_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	prq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

	prq_datapath #(
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.cmd       (cmd),
		.stat      (stat)
	);

endmodule
`default_nettype wire
